@@ src/mtcm_pkg.sv @@
package mtcm_pkg;

   // request opcodes
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // response status codes
   localparam logic [2:0] ST_ADDED   = 3'd0;
   localparam logic [2:0] ST_PRESENT = 3'd1;
   localparam logic [2:0] ST_ZERO    = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_FOUND   = 3'd4;
   localparam logic [2:0] ST_EMPTY   = 3'd5;

   localparam int unsigned SIZE_W  = 16;
   localparam int unsigned INDEX_W = 6;

   typedef struct packed {
      logic              op;
      logic [SIZE_W-1:0] req_width;
      logic [SIZE_W-1:0] req_height;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [INDEX_W-1:0] mode_index;
      logic [SIZE_W-1:0]  out_width;
      logic [SIZE_W-1:0]  out_height;
   } rsp_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic scan;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic quick;
      logic scan_done;
      logic rsp_busy;
   } sts_type;

endpackage

@@ src/mtcm_ram.sv @@
module mtcm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/mtcm_ctrl.sv @@
module mtcm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mtcm_pkg::sts_type sts,
   output mtcm_pkg::cmd_type cmd
);

   import mtcm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         STATE_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = sts.quick ? STATE_FINISH : STATE_SCAN;
            end
         end
         STATE_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = STATE_FINISH;
            end
         end
         STATE_FINISH: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

endmodule

@@ src/mtcm_dp.sv @@
module mtcm_dp #(
   parameter int unsigned MAX_MODES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  mtcm_pkg::req_type req_data,
   output mtcm_pkg::rsp_type rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  mtcm_pkg::cmd_type cmd,
   output mtcm_pkg::sts_type sts
);

   import mtcm_pkg::*;

   localparam int unsigned AW = $clog2(MAX_MODES);
   localparam int unsigned CW = $clog2(MAX_MODES + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_MODES);

   req_type            req_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic               hit_ff, hit_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic [SIZE_W-1:0]  best_w_ff, best_w_in;
   logic [SIZE_W-1:0]  best_h_ff, best_h_in;
   logic [SIZE_W-1:0]  best_gap_ff, best_gap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic                issuing;
   logic                ram_wr_en;
   logic [2*SIZE_W-1:0] ram_rd_data;
   logic [SIZE_W-1:0]   rd_w, rd_h, gap;
   logic                same_w, exact;
   logic                zero_size;

   assign zero_size = (req_ff.req_width == '0) || (req_ff.req_height == '0);
   assign issuing   = cmd.scan && !hit_ff && (issue_ff < count_ff);

   assign rd_w   = ram_rd_data[2*SIZE_W-1:SIZE_W];
   assign rd_h   = ram_rd_data[SIZE_W-1:0];
   assign same_w = (rd_w == req_ff.req_width);
   assign exact  = same_w && (rd_h == req_ff.req_height);
   assign gap    = (rd_h >= req_ff.req_height) ? (rd_h - req_ff.req_height)
                                               : (req_ff.req_height - rd_h);

   mtcm_ram #(
      .WIDTH (2 * SIZE_W),
      .DEPTH (MAX_MODES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_ff.req_width, req_ff.req_height}),
      .rd_en   (issuing),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // scan: one read per cycle, compare on the registered read data
   always_comb begin
      issue_in    = issue_ff;
      rd_valid_in = issuing;
      rd_idx_in   = issuing ? issue_ff[AW-1:0] : rd_idx_ff;
      hit_in      = hit_ff;
      best_idx_in = best_idx_ff;
      best_w_in   = best_w_ff;
      best_h_in   = best_h_ff;
      best_gap_in = best_gap_ff;
      if (cmd.load_req) begin
         issue_in = '0;
         hit_in   = 1'b0;
      end else if (cmd.scan) begin
         if (issuing) begin
            issue_in = issue_ff + 1'b1;
         end
         if (rd_valid_ff && !hit_ff) begin
            if (exact) begin
               hit_in      = 1'b1;
               best_idx_in = rd_idx_ff;
               best_w_in   = rd_w;
               best_h_in   = rd_h;
               best_gap_in = gap;
            end else if ((rd_idx_ff == '0) || (same_w && (gap < best_gap_ff))) begin
               // entry 0 is the starting candidate whatever its width
               best_idx_in = rd_idx_ff;
               best_w_in   = rd_w;
               best_h_in   = rd_h;
               best_gap_in = gap;
            end
         end
      end
   end

   // result formation and table append
   always_comb begin
      rsp_in    = rsp_ff;
      count_in  = count_ff;
      ram_wr_en = 1'b0;
      if (cmd.load_rsp) begin
         rsp_in = '0;
         if (req_ff.op == OP_ADD) begin
            if (zero_size) begin
               rsp_in.status = ST_ZERO;
            end else if (hit_ff) begin
               rsp_in.status = ST_PRESENT;
            end else if (count_ff >= COUNT_MAX) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.status = ST_ADDED;
               ram_wr_en     = 1'b1;
               count_in      = count_ff + 1'b1;
            end
         end else if (count_ff == '0) begin
            rsp_in.status     = ST_EMPTY;
            rsp_in.out_width  = req_ff.req_width;
            rsp_in.out_height = req_ff.req_height;
         end else begin
            rsp_in.status     = ST_FOUND;
            rsp_in.mode_index = INDEX_W'(best_idx_ff);
            rsp_in.out_width  = best_w_ff;
            rsp_in.out_height = best_h_ff;
         end
      end
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_w_ff   <= best_w_in;
      best_h_ff   <= best_h_in;
      best_gap_ff <= best_gap_in;
      rsp_ff      <= rsp_in;
   end

   assign sts.quick = ((req_data.op == OP_ADD) &&
                       ((req_data.req_width == '0) || (req_data.req_height == '0))) ||
                      ((req_data.op == OP_LOOKUP) && (count_ff == '0));
   assign sts.scan_done = hit_ff || ((issue_ff >= count_ff) && !rd_valid_ff);
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("mode count beyond table depth");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (CW'(rd_idx_ff) < count_ff))
      else $error("scan read beyond stored entries");

   a_found_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == ST_FOUND)) |-> (count_ff != '0))
      else $error("lookup found on empty table");

   a_add_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_ff.status == ST_ADDED) || (rsp_ff.status == ST_PRESENT) ||
                        (rsp_ff.status == ST_ZERO) || (rsp_ff.status == ST_FULL)))
      |-> ((rsp_ff.mode_index == '0) && (rsp_ff.out_width == '0) &&
           (rsp_ff.out_height == '0)))
      else $error("add response carries nonzero fields");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("append did not advance count");
`endif

endmodule

@@ src/mode_table_closest_match_core.sv @@
// Mode table with closest-match lookup. An add request (op 0) stores a width/height pair:
// a zero width or height is rejected, a pair already stored is reported as present, and a
// new pair is refused once MAX_MODES entries are held. A lookup (op 1) walks the table in
// order, stops at the first exact match, and otherwise returns the entry with the smallest
// height difference among entries of the requested width, starting from entry 0 whatever
// its width; ties keep the earlier entry. An empty table returns status empty with the
// requested size echoed. One request is in flight at a time. A request that walks the table
// reads the stored entries one per cycle through the single read port of the table RAM,
// ending early on an exact match, and its response is registered once the walk is done.
// A zero-size add or a lookup on an empty table skips the walk. The next request is taken
// while a finished response still waits on rsp_ready. The table needs no clearing after
// reset: only entries below the fill count are ever read.
module mode_table_closest_match_core #(
   parameter int unsigned MAX_MODES = 64
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  mtcm_pkg::req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mtcm_pkg::rsp_type rsp_data
);

   import mtcm_pkg::*;

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: idle, table walk, response hand-off
   mtcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table RAM, fill count, compare stage and response register
   mtcm_dp #(
      .MAX_MODES (MAX_MODES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

@@ tb/sv/tb_mode_table_closest_match_core.sv @@
module tb_mode_table_closest_match_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mtcm_pkg::*;

   // table depth of the instance under test
   localparam int unsigned MODE_SLOTS   = 64;
   // quiet tail length, derived from the table depth
   localparam int unsigned SETTLE_WAIT  = MODE_SLOTS + 16;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned REPORT_LIMIT = 10;

   // clock and reset
   logic    clock = 1'b0;
   logic    reset = 1'b1;

   // request channel
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;

   // response channel
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the mode table
   logic [SIZE_W-1:0] table_widths  [MODE_SLOTS];
   logic [SIZE_W-1:0] table_heights [MODE_SLOTS];
   int unsigned       table_fill = 0;

   // responses still owed by the block, oldest first
   rsp_type           pending_rsps [$];

   // run bookkeeping
   bit          idle_on      = 1'b0;
   int unsigned cycle_count  = 0;
   int unsigned fail_count   = 0;
   int unsigned add_count    = 0;
   int unsigned lookup_count = 0;
   int unsigned rsp_count    = 0;
   int unsigned status_seen [8];

   mode_table_closest_match_core #(
      .MAX_MODES (MODE_SLOTS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_rsps.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // absolute height difference, wide enough to never wrap
   function automatic int unsigned height_gap(input logic [SIZE_W-1:0] a,
                                              input logic [SIZE_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   // expected response for one request; updates the shadow table on adds
   function automatic rsp_type predict_mode_rsp(input req_type r);
      rsp_type     p;
      int unsigned best;
      bit          present;
      p = '0;
      if (r.op == OP_ADD) begin
         // zero size is checked before anything else
         if (r.req_width == '0 || r.req_height == '0) begin
            p.status = ST_ZERO;
         end else begin
            present = 1'b0;
            for (int i = 0; i < table_fill; i++) begin
               if (table_widths[i] == r.req_width && table_heights[i] == r.req_height)
                  present = 1'b1;
            end
            // a duplicate wins over a full table
            if (present) begin
               p.status = ST_PRESENT;
            end else if (table_fill >= MODE_SLOTS) begin
               p.status = ST_FULL;
            end else begin
               table_widths[table_fill]  = r.req_width;
               table_heights[table_fill] = r.req_height;
               table_fill++;
               p.status = ST_ADDED;
            end
         end
      end else if (table_fill == 0) begin
         // empty table echoes the requested size
         p.status     = ST_EMPTY;
         p.out_width  = r.req_width;
         p.out_height = r.req_height;
      end else begin
         // entry 0 is the starting candidate whatever its width
         best = 0;
         for (int i = 0; i < table_fill; i++) begin
            if (table_widths[i] == r.req_width) begin
               if (table_heights[i] == r.req_height) begin
                  best = i;
                  break;
               end
               // strict compare, so ties keep the earlier entry
               if (height_gap(table_heights[i], r.req_height) <
                   height_gap(table_heights[best], r.req_height))
                  best = i;
            end
         end
         p.status     = ST_FOUND;
         p.mode_index = INDEX_W'(best);
         p.out_width  = table_widths[best];
         p.out_height = table_heights[best];
      end
      return p;
   endfunction

   // a handful of widths so lookups mostly hit populated columns
   function automatic logic [SIZE_W-1:0] pool_width();
      case ($urandom_range(0, 6))
         0:       return 16'd1;
         1:       return 16'd320;
         2:       return 16'd640;
         3:       return 16'd800;
         4:       return 16'd1024;
         5:       return 16'h8000;
         default: return 16'hFFFF;
      endcase
   endfunction

   // random request: mostly well-formed adds and lookups, some raw noise
   function automatic req_type make_request(input int unsigned add_pct);
      req_type     r;
      int unsigned pick;
      int unsigned slot;
      pick         = $urandom_range(0, 99);
      slot         = (table_fill != 0) ? $urandom_range(0, table_fill - 1) : 0;
      r.op         = OP_LOOKUP;
      r.req_width  = pool_width();
      r.req_height = SIZE_W'($urandom);
      if (pick < 8) begin
         // noise over the whole field range
         r.op         = 1'($urandom);
         r.req_width  = SIZE_W'($urandom);
         r.req_height = SIZE_W'($urandom);
      end else if (pick < 8 + add_pct) begin
         r.op = OP_ADD;
         case ($urandom_range(0, 9))
            0: r.req_width  = '0;
            1: r.req_height = '0;
            2, 3: begin
               // duplicate of a stored pair
               if (table_fill != 0) begin
                  r.req_width  = table_widths[slot];
                  r.req_height = table_heights[slot];
               end
            end
            4, 5: begin
               // neighbor of a stored pair, sets up near ties
               if (table_fill != 0) begin
                  r.req_width  = table_widths[slot];
                  r.req_height = table_heights[slot] + SIZE_W'($urandom_range(0, 6)) - 16'd3;
               end
            end
            default: ;
         endcase
      end else if (table_fill != 0 && $urandom_range(0, 2) != 0) begin
         // lookup at or near a stored pair
         r.req_width  = table_widths[slot];
         r.req_height = table_heights[slot] + SIZE_W'($urandom_range(0, 4)) - 16'd2;
      end
      return r;
   endfunction

   // drive one request and wait for its acceptance
   task automatic send_request(input req_type r);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsps.push_back(predict_mode_rsp(r));
      if (r.op == OP_ADD) add_count++;
      else lookup_count++;
   endtask

   task automatic send_mode(input logic op, input int unsigned w, input int unsigned h);
      req_type r;
      r.op         = op;
      r.req_width  = SIZE_W'(w);
      r.req_height = SIZE_W'(h);
      send_request(r);
   endtask

   // hold off new requests until every response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   // response sink with random stall bursts
   initial begin : rsp_stall_gen
      int unsigned hold;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 11) == 0) begin
            hold = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin : rsp_checker
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         status_seen[rsp_data.status]++;
         if (pending_rsps.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: response with no request waiting: status %0d index %0d %0dx%0d",
                        $time, rsp_data.status, rsp_data.mode_index,
                        rsp_data.out_width, rsp_data.out_height);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_data.status     !== want.status     ||
                rsp_data.mode_index !== want.mode_index ||
                rsp_data.out_width  !== want.out_width  ||
                rsp_data.out_height !== want.out_height) begin
               fail_count++;
               // fields are status, index and width x height
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: mismatch exp %0d %0d %0dx%0d got %0d %0d %0dx%0d",
                           $time, want.status, want.mode_index,
                           want.out_width, want.out_height,
                           rsp_data.status, rsp_data.mode_index,
                           rsp_data.out_width, rsp_data.out_height);
            end
         end
      end
   end

   // lookups and zero-size adds before anything is stored
   task automatic test_empty_table();
      send_mode(OP_LOOKUP, 0, 0);
      send_mode(OP_ADD, 0, 0);
      send_mode(OP_LOOKUP, 16'hFFFF, 16'hFFFF);
      send_mode(OP_ADD, 0, 480);
      send_mode(OP_ADD, 640, 0);
      send_mode(OP_LOOKUP, 640, 480);
   endtask

   // entry 0 bias, ties, exact hits, duplicates and field extremes
   task automatic test_directed_lookups();
      send_mode(OP_ADD, 1, 1);                  // entry 0, odd width
      send_mode(OP_ADD, 640, 60000);
      send_mode(OP_LOOKUP, 640, 0);             // entry 0 is closer in height
      send_mode(OP_LOOKUP, 640, 16'hFFFF);      // same-width entry beats entry 0
      send_mode(OP_LOOKUP, 2, 2);               // no such width, entry 0
      send_mode(OP_ADD, 640, 480);
      send_mode(OP_ADD, 640, 482);
      send_mode(OP_LOOKUP, 640, 481);           // tie keeps the earlier entry
      send_mode(OP_LOOKUP, 640, 482);           // exact hit
      send_mode(OP_ADD, 640, 480);              // already present
      send_mode(OP_ADD, 0, 16'hFFFF);
      send_mode(OP_ADD, 16'hFFFF, 0);
      send_mode(OP_ADD, 16'hFFFF, 16'hFFFF);
      send_mode(OP_LOOKUP, 16'hFFFF, 0);        // entry 0 still wins
      send_mode(OP_LOOKUP, 16'hFFFF, 16'hFFFF);
      send_mode(OP_LOOKUP, 1, 1);               // exact hit on entry 0
      send_mode(OP_ADD, 1, 16'hFFFF);
      send_mode(OP_LOOKUP, 1, 40000);           // later entry of width 1
   endtask

   // random mix with idling until the table is full
   task automatic test_fill_table();
      idle_on = 1'b1;
      while (table_fill < MODE_SLOTS) send_request(make_request(55));
   endtask

   // full table: duplicates, refusals and long scans, with one drain pause
   task automatic test_full_table();
      for (int k = 0; k < 800; k++) begin
         // alternate stretches with and without idling
         idle_on = ((k / 100) % 2) == 0;
         if (k == 400) wait_drained();
         send_request(make_request(30));
      end
   endtask

   // closing stretch at full rate on both sides
   task automatic test_back_to_back();
      idle_on = 1'b0;
      for (int k = 0; k < 450; k++) send_request(make_request(25));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_directed_lookups();
      test_fill_table();
      test_full_table();
      test_back_to_back();

      // let the last responses come back, then a quiet tail
      wait_drained();
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("checked %0d responses for %0d adds and %0d lookups, table holds %0d of %0d",
               rsp_count, add_count, lookup_count, table_fill, MODE_SLOTS);
      $display("status mix: added %0d present %0d zero %0d full %0d found %0d empty %0d",
               status_seen[ST_ADDED], status_seen[ST_PRESENT], status_seen[ST_ZERO],
               status_seen[ST_FULL], status_seen[ST_FOUND], status_seen[ST_EMPTY]);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/mtcm_pkg.sv
src/mtcm_ram.sv
src/mtcm_ctrl.sv
src/mtcm_dp.sv
src/mode_table_closest_match_core.sv
tb/sv/tb_mode_table_closest_match_core.sv
